### design/tcop_pkg.sv
// ----------------------------------------------------------------------------
// tcop_pkg
// shared types, constants and helpers of the tilted circle outline core
// ----------------------------------------------------------------------------
package tcop_pkg;

  localparam int DefSamples     = 1000;
  localparam int DefCordicSteps = 16;
  localparam int DefMaxHalfSize = 1023;

  localparam logic signed [35:0] QOne  = 36'sd1073741824;
  localparam logic signed [35:0] QGain = 36'sd652032874;
  localparam int SqrtSteps = 32;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_YAW    = 3'd1,
    REG_PITCH  = 3'd2,
    REG_HALF_H = 3'd3,
    REG_HALF_W = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PT_CENTRE = 3'd0,
    PT_DOWN   = 3'd1,
    PT_UP     = 3'd2,
    PT_RIGHT  = 3'd3,
    PT_LEFT   = 3'd4
  } pt_t;

  typedef logic signed [35:0] q_t;

  typedef struct packed {
    logic       mode;
    logic [9:0] sample_index;
  } sample_t;

  typedef struct packed {
    logic signed [11:0] pixel_row;
    logic signed [11:0] pixel_col;
    logic               in_grid;
    logic               last_point;
  } pixel_t;

  typedef struct packed {
    q_t                 x;
    q_t                 y;
    logic signed [32:0] z;
  } rot_t;

  typedef struct packed {
    logic             mode;
    logic [9:0]       hh;
    logic [9:0]       hw;
    logic [16:0]      r16;
    logic [2:0][31:0] ang;
    logic [2:0]       flip;
    rot_t [2:0]       rot;
    logic [63:0]      sq_v;
    logic [63:0]      sq_res;
  } pipe_t;

  typedef struct packed {
    logic               mode;
    logic [9:0]         hh;
    logic [9:0]         hw;
    logic signed [17:0] row;
    logic signed [17:0] col;
  } emit_t;

  function automatic logic [29:0] arc_tan(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [71:0] p;
    p = 72'(a) * 72'(b);
    return q_t'(p >>> 30);
  endfunction

endpackage

### design/tcop_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tcop_sqrt_cell
// one digit step of the square root chain, one result bit per cell
// ----------------------------------------------------------------------------
module tcop_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          din_valid,
  input  tcop_pkg::pipe_t din,
  output logic          dout_valid,
  output tcop_pkg::pipe_t dout
);
  import tcop_pkg::*;

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * STEP);

  pipe_t       dout_next;
  logic [63:0] trial;

  always_comb begin
    dout_next = din;
    trial     = din.sq_res + Bit;
    if (din.sq_v >= trial) begin
      dout_next.sq_v   = din.sq_v - trial;
      dout_next.sq_res = (din.sq_res >> 1) + Bit;
    end else begin
      dout_next.sq_res = din.sq_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (adv) begin
      dout_valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

### design/tcop_cordic_cell.sv
// ----------------------------------------------------------------------------
// tcop_cordic_cell
// one rotation step for the sample, yaw and pitch angles side by side
// ----------------------------------------------------------------------------
module tcop_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          din_valid,
  input  tcop_pkg::pipe_t din,
  output logic          dout_valid,
  output tcop_pkg::pipe_t dout
);
  import tcop_pkg::*;

  localparam logic signed [32:0] Atan = 33'(arc_tan(STEP));

  pipe_t dout_next;

  always_comb begin
    dout_next = din;
    for (int l = 0; l < 3; l++) begin
      if (!din.rot[l].z[32]) begin
        dout_next.rot[l].x = din.rot[l].x - (din.rot[l].y >>> STEP);
        dout_next.rot[l].y = din.rot[l].y + (din.rot[l].x >>> STEP);
        dout_next.rot[l].z = din.rot[l].z - Atan;
      end else begin
        dout_next.rot[l].x = din.rot[l].x + (din.rot[l].y >>> STEP);
        dout_next.rot[l].y = din.rot[l].y - (din.rot[l].x >>> STEP);
        dout_next.rot[l].z = din.rot[l].z + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
    end else if (adv) begin
      dout_valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

### design/tcop_emit.sv
// ----------------------------------------------------------------------------
// tcop_emit
// output register: sends one outline pixel or the five pixels of the cross
// ----------------------------------------------------------------------------
module tcop_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  tcop_pkg::emit_t din,
  output logic           free,
  output logic           pixel_valid,
  input  logic           pixel_stall,
  output tcop_pkg::pixel_t pixel
);
  import tcop_pkg::*;

  emit_t              base;
  pt_t                idx;
  logic               last;
  logic signed [18:0] row;
  logic signed [18:0] col;
  logic signed [18:0] row_max;
  logic signed [18:0] col_max;

  assign last = !base.mode || (idx == PT_LEFT);
  assign free = !pixel_valid || (!pixel_stall && last);

  always_comb begin
    row = 19'(base.row);
    col = 19'(base.col);
    case (idx)
      PT_DOWN:  row = row + 19'sd1;
      PT_UP:    row = row - 19'sd1;
      PT_RIGHT: col = col + 19'sd1;
      PT_LEFT:  col = col - 19'sd1;
      default:  ;
    endcase
    row_max = $signed({8'b0, base.hh, 1'b0});
    col_max = $signed({8'b0, base.hw, 1'b0});
    pixel.in_grid    = (row >= 19'sd0) && (row <= row_max) &&
                       (col >= 19'sd0) && (col <= col_max);
    pixel.last_point = last;
    if (row < -19'sd1) begin
      pixel.pixel_row = -12'sd1;
    end else if (row > 19'sd2047) begin
      pixel.pixel_row = 12'sd2047;
    end else begin
      pixel.pixel_row = row[11:0];
    end
    if (col < -19'sd1) begin
      pixel.pixel_col = -12'sd1;
    end else if (col > 19'sd2047) begin
      pixel.pixel_col = 12'sd2047;
    end else begin
      pixel.pixel_col = col[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      idx         <= PT_CENTRE;
    end else if (load) begin
      pixel_valid <= 1'b1;
      idx         <= PT_CENTRE;
    end else if (pixel_valid && !pixel_stall) begin
      if (last) begin
        pixel_valid <= 1'b0;
      end else begin
        idx <= pt_t'(idx + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      base <= din;
    end
  end

endmodule

### design/tilted_circle_outline_points_core.sv
// ----------------------------------------------------------------------------
// tilted_circle_outline_points_core
// projects a tilted circle on the unit sphere onto a pixel grid
// ----------------------------------------------------------------------------
// Usage: a request on the sample channel (sample_valid, sample_stall, sample)
// carries a mode and a sample index. Mode 0 yields one outline pixel, mode 1
// yields the five pixels of the centre cross, the last one flagged by
// last_point. Results leave on the pixel channel (pixel_valid, pixel_stall).
// Circle and grid settings are written on the cfg channel, which is always
// ready; write them only while no request is in flight.
// From acceptance to the first result a request passes five angle stages,
// 32 square root cells, one cell per rotation step, eight multiply stages
// and the output register.
// Throughput: one request per cycle in mode 0 unless the receiver stalls;
// a mode 1 request holds the output register until its five pixels leave.
// Reset empties the whole pipeline and restores the default settings.
// While the receiver stalls, the pipeline keeps moving until its last stage
// is full; then it holds and sample_stall is raised.
// ----------------------------------------------------------------------------
module tilted_circle_outline_points_core #(
  parameter int SAMPLES       = tcop_pkg::DefSamples,
  parameter int CORDIC_STEPS  = tcop_pkg::DefCordicSteps,
  parameter int MAX_HALF_SIZE = tcop_pkg::DefMaxHalfSize
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tcop_pkg::sample_t sample,
  output logic              pixel_valid,
  input  logic              pixel_stall,
  output tcop_pkg::pixel_t  pixel,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [16:0]       cfg_data
);
  import tcop_pkg::*;

  localparam int    Steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int    NW    = 10 + $clog2(SAMPLES);
  localparam int    PW    = NW + 32;
  localparam longint QRec = 64'sd4294967296 / SAMPLES;
  localparam longint RRem = 64'sd4294967296 % SAMPLES;

  typedef struct packed {
    logic mode;
    logic [9:0] hh;
    logic [9:0] hw;
    q_t r, s, ct, st, cth, sth, cph, sph;
    q_t a, b, c, d, e, h;
    q_t xv, yv;
    logic signed [47:0] px, py;
  } math_t;

  logic [16:0] radius;
  logic [15:0] yaw_angle;
  logic [15:0] pitch_angle;
  logic [9:0]  half_height;
  logic [9:0]  half_width;

  logic        adv;
  logic        emit_free;
  emit_t       emit_in;

  // angle preparation
  pipe_t       p0, p1, p2, p3, p4;
  logic        v0, v1, v2, v3, v4;
  logic [NW-1:0] n0, n1;
  logic [31:0] kq0, kq1, kq2;
  logic [PW-1:0] prod1;
  logic [NW-1:0] q2;
  logic        corr2;
  logic [NW:0] qs;
  logic [33:0] rsq;
  pipe_t       p0_next, p4_next;

  pipe_t       sq_d [SqrtSteps+1];
  logic        sq_v [SqrtSteps+1];
  pipe_t       co_d [Steps+1];
  logic        co_v [Steps+1];

  math_t       m [8];
  logic        mv [8];
  q_t          trig [6];

  function automatic logic [NW-1:0] q2_from_prod(input logic [PW-1:0] p);
    return p[PW-1:32];
  endfunction

  assign cfg_ready    = 1'b1;
  assign adv          = !mv[7] || emit_free;
  assign sample_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= 17'd32768;
      yaw_angle   <= 16'd0;
      pitch_angle <= 16'd0;
      half_height <= 10'd98;
      half_width  <= 10'd98;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIUS: radius      <= cfg_data;
        REG_YAW:    yaw_angle   <= cfg_data[15:0];
        REG_PITCH:  pitch_angle <= cfg_data[15:0];
        REG_HALF_H: half_height <= cfg_data[9:0];
        REG_HALF_W: half_width  <= cfg_data[9:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    p0_next        = '0;
    p0_next.mode   = sample.mode;
    p0_next.r16    = (radius > 17'd65536) ? 17'd65536 : radius;
    p0_next.hh     = (half_height > 10'(MAX_HALF_SIZE)) ? 10'(MAX_HALF_SIZE) : half_height;
    p0_next.hw     = (half_width > 10'(MAX_HALF_SIZE)) ? 10'(MAX_HALF_SIZE) : half_width;
    p0_next.ang[1] = {yaw_angle, 16'd0};
    p0_next.ang[2] = {pitch_angle, 16'd0};
    rsq            = 34'(p0_next.r16) * 34'(p0_next.r16);
    p0_next.sq_v   = ((64'd1 << 32) - 64'(rsq)) << 28;
  end

  assign qs = (NW + 1)'(q2_from_prod(prod1)) * (NW + 1)'(SAMPLES);

  always_comb begin
    p4_next = p3;
    for (int l = 0; l < 3; l++) begin
      logic [31:0] a;
      logic [31:0] sum;
      sum = p3.ang[l] + 32'h4000_0000;
      p4_next.flip[l] = sum[31];
      a = sum[31] ? (p3.ang[l] + 32'h8000_0000) : p3.ang[l];
      p4_next.rot[l].x = QGain;
      p4_next.rot[l].y = '0;
      p4_next.rot[l].z = $signed({a[31], a});
    end
    p4_next.sq_res = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v0 <= sample_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0    <= p0_next;
      n0    <= NW'(sample.sample_index) * NW'(RRem) + NW'(SAMPLES / 2);
      kq0   <= 32'(42'(sample.sample_index) * 42'(QRec));
      p1    <= p0;
      n1    <= n0;
      kq1   <= kq0;
      prod1 <= PW'(n0) * PW'(QRec);
      p2    <= p1;
      kq2   <= kq1;
      q2    <= q2_from_prod(prod1);
      corr2 <= ((NW + 1)'(n1) - qs) >= (NW + 1)'(SAMPLES);
      p3    <= p2;
      p3.ang[0] <= 32'h8000_0000 + kq2 + 32'(q2) + 32'(corr2);
      p4    <= p4_next;
    end
  end

  assign sq_d[0] = p4;
  assign sq_v[0] = v4;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    tcop_sqrt_cell #(.STEP(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .din_valid  (sq_v[i]),
      .din        (sq_d[i]),
      .dout_valid (sq_v[i+1]),
      .dout       (sq_d[i+1])
    );
  end

  assign co_d[0] = sq_d[SqrtSteps];
  assign co_v[0] = sq_v[SqrtSteps];

  for (genvar i = 0; i < Steps; i++) begin : g_cordic
    tcop_cordic_cell #(.STEP(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .din_valid  (co_v[i]),
      .din        (co_d[i]),
      .dout_valid (co_v[i+1]),
      .dout       (co_d[i+1])
    );
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      trig[2*l]   = co_d[Steps].flip[l] ? -co_d[Steps].rot[l].x : co_d[Steps].rot[l].x;
      trig[2*l+1] = co_d[Steps].flip[l] ? -co_d[Steps].rot[l].y : co_d[Steps].rot[l].y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        mv[i] <= 1'b0;
      end
    end else if (adv) begin
      mv[0] <= co_v[Steps];
      for (int i = 1; i < 8; i++) begin
        mv[i] <= mv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m[0]      <= '0;
      m[0].mode <= co_d[Steps].mode;
      m[0].hh   <= co_d[Steps].hh;
      m[0].hw   <= co_d[Steps].hw;
      m[0].r    <= q_t'({co_d[Steps].r16, 14'd0});
      m[0].s    <= q_t'(co_d[Steps].sq_res);
      m[0].ct   <= trig[0];
      m[0].st   <= trig[1];
      m[0].cth  <= trig[2];
      m[0].sth  <= trig[3];
      m[0].cph  <= trig[4];
      m[0].sph  <= trig[5];

      m[1]   <= m[0];
      m[1].a <= qmul(m[0].r, m[0].ct);
      m[1].b <= qmul(m[0].s, m[0].sth);
      m[1].c <= qmul(m[0].r, m[0].sth);
      m[1].d <= qmul(m[0].s, m[0].cth);
      m[1].e <= qmul(m[0].r, m[0].st);
      m[1].h <= qmul(m[0].s, m[0].sph);

      m[2]   <= m[1];
      m[2].a <= qmul(m[1].a, m[1].cth);
      m[2].c <= qmul(m[1].c, m[1].ct);
      m[2].e <= qmul(m[1].e, m[1].cph);
      m[2].h <= qmul(m[1].h, m[1].cth);

      m[3]    <= m[2];
      m[3].xv <= m[2].mode ? (m[2].b + QOne) : (m[2].a + m[2].b + QOne);
      m[3].c  <= m[2].c - m[2].d;

      m[4]   <= m[3];
      m[4].c <= qmul(m[3].c, m[3].sph);

      m[5]    <= m[4];
      m[5].yv <= m[4].mode ? (QOne - m[4].h) : (m[4].c + m[4].e + QOne);

      m[6]    <= m[5];
      m[6].px <= 48'(m[5].xv) * $signed({38'd0, m[5].hh}) + 48'sd536870912;
      m[6].py <= 48'(m[5].yv) * $signed({38'd0, (m[5].mode ? m[5].hh : m[5].hw)})
                 + 48'sd536870912;

      m[7] <= m[6];
    end
  end

  always_comb begin
    emit_in.mode = m[7].mode;
    emit_in.hh   = m[7].hh;
    emit_in.hw   = m[7].hw;
    emit_in.row  = 18'(m[7].py >>> 30);
    emit_in.col  = 18'(m[7].px >>> 30);
  end

  tcop_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .load        (adv && mv[7]),
    .din         (emit_in),
    .free        (emit_free),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

endmodule

### design/tcop_checker.sv
// ----------------------------------------------------------------------------
// tcop_checker
// port level checks of the tilted circle outline core
// ----------------------------------------------------------------------------
module tcop_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input tcop_pkg::sample_t sample,
  input logic              pixel_valid,
  input logic              pixel_stall,
  input tcop_pkg::pixel_t  pixel
);
  import tcop_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("result after reset");

  a_grid: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel.in_grid |-> !pixel.pixel_row[11] && !pixel.pixel_col[11])
    else $error("in grid pixel with negative coordinate");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> pixel_valid)
    else $error("request stalled with empty output");

endmodule

bind tilted_circle_outline_points_core tcop_checker u_tcop_checker (.*);

### dv/tb_tilted_circle_outline_points_core.sv
// ----------------------------------------------------------------------------
// tb_tilted_circle_outline_points_core
// self-checking bench: a bit-exact predictor computes the pixels of each
// request, a checker compares every result in order, and named test tasks
// cover directed corners, random sweeps, idling phases and back pressure
// ----------------------------------------------------------------------------
module tb_tilted_circle_outline_points_core;
  import tcop_pkg::*;

  localparam int NSamples = 1000;
  localparam int NSteps   = 16;
  localparam int MaxHalf  = 1023;
  localparam int Latency  = NSteps + 46;
  localparam int WdLimit  = 20000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample = '0;
  logic    pixel_valid;
  logic    pixel_stall = 1'b0;
  pixel_t  pixel;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int quiet = 0;

  logic [16:0] radius_q;
  logic [15:0] yaw_q, pitch_q;
  logic [9:0]  hh_q, hw_q;

  pixel_t pending_pixels[$];

  tilted_circle_outline_points_core dut (
    .clk, .rst, .sample_valid, .sample_stall, .sample,
    .pixel_valid, .pixel_stall, .pixel,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  function automatic longint sar(longint v, int sh);
    if (v >= 0) return v >>> sh;
    return -64'sd1 - ((-64'sd1 - v) >>> sh);
  endfunction

  function automatic longint mulq(longint a, longint b);
    return sar(a * b, 30);
  endfunction

  function automatic longint arc_q(int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  task automatic cordic(input logic [31:0] ang, output longint c, output longint s);
    bit flip;
    longint x, y, z, nx;
    flip = ((ang + 32'h4000_0000) & 32'h8000_0000) != 0;
    x = 652032874;
    y = 0;
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'($signed(ang));
    for (int i = 0; i < NSteps; i++) begin
      if (z >= 0) begin
        nx = x - sar(y, i); y = y + sar(x, i); z -= arc_q(i);
      end else begin
        nx = x + sar(y, i); y = y - sar(x, i); z += arc_q(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint to_pix(longint q);
    return sar(q + 64'sd536870912, 30);
  endfunction

  function automatic pixel_t make_pixel(longint row, longint col, int hh, int hw, bit last);
    pixel_t p;
    p.in_grid = row >= 0 && row <= 2 * hh && col >= 0 && col <= 2 * hw;
    if (row < -1) row = -1;
    if (row > 2047) row = 2047;
    if (col < -1) col = -1;
    if (col > 2047) col = 2047;
    p.pixel_row = row[11:0];
    p.pixel_col = col[11:0];
    p.last_point = last;
    return p;
  endfunction

  task automatic predict_pixels(input sample_t req);
    longint unsigned r16, k;
    longint r, s, cth, sth, cph, sph, ct, st, x, y, cx, cy;
    int hh, hw;
    logic [31:0] t;
    r16 = radius_q > 65536 ? 65536 : radius_q;
    hh = hh_q > MaxHalf ? MaxHalf : hh_q;
    hw = hw_q > MaxHalf ? MaxHalf : hw_q;
    r = longint'(r16 << 14);
    s = root64((64'd4294967296 - r16 * r16) << 28);
    cordic({yaw_q, 16'h0}, cth, sth);
    cordic({pitch_q, 16'h0}, cph, sph);
    if (!req.mode) begin
      k = req.sample_index;
      t = 32'h8000_0000 + 32'((((k << 32) + NSamples / 2) / NSamples));
      cordic(t, ct, st);
      x = mulq(mulq(r, ct), cth) + mulq(s, sth) + 64'sd1073741824;
      y = mulq(mulq(mulq(r, sth), ct) - mulq(s, cth), sph) + mulq(mulq(r, st), cph)
          + 64'sd1073741824;
      pending_pixels.push_back(make_pixel(to_pix(y * hw), to_pix(x * hh), hh, hw, 1'b1));
    end else begin
      cx = to_pix((mulq(s, sth) + 64'sd1073741824) * hh);
      cy = to_pix((64'sd1073741824 - mulq(mulq(s, sph), cth)) * hh);
      pending_pixels.push_back(make_pixel(cy, cx, hh, hw, 1'b0));
      pending_pixels.push_back(make_pixel(cy + 1, cx, hh, hw, 1'b0));
      pending_pixels.push_back(make_pixel(cy - 1, cx, hh, hw, 1'b0));
      pending_pixels.push_back(make_pixel(cy, cx + 1, hh, hw, 1'b0));
      pending_pixels.push_back(make_pixel(cy, cx - 1, hh, hw, 1'b1));
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // receiver stall and result check
  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      pixel_stall <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        if (pending_pixels.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          want = pending_pixels.pop_front();
          if (pixel.pixel_row !== want.pixel_row)
            report_mismatch("pixel_row", pixel.pixel_row, want.pixel_row);
          if (pixel.pixel_col !== want.pixel_col)
            report_mismatch("pixel_col", pixel.pixel_col, want.pixel_col);
          if (pixel.in_grid !== want.in_grid)
            report_mismatch("in_grid", pixel.in_grid, want.in_grid);
          if (pixel.last_point !== want.last_point)
            report_mismatch("last_point", pixel.last_point, want.last_point);
        end
      end
      if (hold_cycles > 0) begin
        pixel_stall <= 1'b1;
        hold_cycles <= hold_cycles - 1;
      end else pixel_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (pixel_valid && !pixel_stall) || rst
        || hold_cycles > 0)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WdLimit) begin
      $display("tb_tilted_circle_outline_points_core: done, errors");
      $finish;
    end
  end

  // valid stays high after acceptance until the next request or an idle cycle
  task automatic send_request(input logic m, input logic [9:0] k);
    sample_t req;
    req.mode = m;
    req.sample_index = k;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= req;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predict_pixels(req);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RADIUS: radius_q = val;
      REG_YAW:    yaw_q = val[15:0];
      REG_PITCH:  pitch_q = val[15:0];
      REG_HALF_H: hh_q = val[9:0];
      REG_HALF_W: hw_q = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_circle(input logic [16:0] r, input logic [15:0] yw,
                            input logic [15:0] pt, input logic [9:0] hh,
                            input logic [9:0] hw);
    drain();
    write_reg(REG_RADIUS, r);
    write_reg(REG_YAW, {1'b0, yw});
    write_reg(REG_PITCH, {1'b0, pt});
    write_reg(REG_HALF_H, {7'd0, hh});
    write_reg(REG_HALF_W, {7'd0, hw});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed();
    send_request(1'b0, 10'd0);
    send_request(1'b0, 10'd999);
    send_request(1'b0, 10'd1023);
    send_request(1'b0, 10'd500);
    send_request(1'b1, 10'd0);
    set_circle(17'd65536, 16'h4000, 16'hc000, 10'd1023, 10'd1);
    send_request(1'b0, 10'd250);
    send_request(1'b1, 10'h3ff);
    set_circle(17'h1ffff, 16'h8000, 16'h7fff, 10'd0, 10'd0);
    send_request(1'b0, 10'd1);
    send_request(1'b1, 10'd0);
    set_circle(17'd0, 16'h2000, 16'h2000, 10'd1, 10'd1023);
    send_request(1'b0, 10'd750);
    send_request(1'b1, 10'd5);
    set_circle(17'd60000, 16'h1000, 16'hf000, 10'd16, 10'd16);
    for (int i = 0; i < 8; i++) send_request(1'(i & 1), 10'(i * 131));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_request($urandom_range(99) < 25, 10'($urandom_range(1023)));
  endtask

  task automatic random_circle();
    set_circle(17'($urandom_range(70000)), 16'($urandom), 16'($urandom),
               10'($urandom_range(1, 300)), 10'($urandom_range(1, 300)));
  endtask

  task automatic test_idling();
    int pct[4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{22, 22}};
    for (int p = 0; p < 4; p++) begin
      random_circle();
      send_idle_pct = pct[p][0];
      stall_pct = pct[p][1];
      test_random(80);
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_back_pressure();
    random_circle();
    @(posedge clk);
    hold_cycles <= 200;
    test_random(80);
    drain();
    test_random(10);
  endtask

  initial begin
    radius_q = 17'd32768;
    yaw_q = '0;
    pitch_q = '0;
    hh_q = 10'd98;
    hw_q = 10'd98;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_idling();
    test_back_pressure();
    set_circle(17'd65536, 16'h7fff, 16'h8000, 10'd1023, 10'd1023);
    test_random(10);
    drain();
    if (errors == 0) $display("tb_tilted_circle_outline_points_core: done, clean");
    else $display("tb_tilted_circle_outline_points_core: done, errors");
    $finish;
  end
endmodule
